// File: src/led_pattern_sequencer_macros.svh
// Assertion macros used by the checker file lps_checker.sv.
`ifndef LED_PATTERN_SEQUENCER_MACROS_SVH
`define LED_PATTERN_SEQUENCER_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted.
`define LPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define LPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/lps_pkg.sv
`default_nettype none

package lps_pkg;

    localparam int LED_WIDTH     = 10;
    localparam int MODE_WIDTH    = 4;
    localparam int FILL_WIDTH    = 5;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int S_DATA_WIDTH  = 8;
    localparam int M_DATA_WIDTH  = 16;
    localparam int DEF_DELAY_WIDTH = 16;

    localparam logic [MODE_WIDTH-1:0] MODE_SCAN  = 4'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_COUNT = 4'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_BLINK = 4'd4;
    localparam logic [MODE_WIDTH-1:0] MODE_TAIL  = 4'd8;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_SCAN_DELAY  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COUNT_DELAY = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BLINK_DELAY = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TAIL_DELAY  = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_IDLE_DELAY  = 3'd4;

    localparam logic [CFG_WIDTH-1:0] SCAN_DELAY_RST  = 16'd75;
    localparam logic [CFG_WIDTH-1:0] COUNT_DELAY_RST = 16'd50;
    localparam logic [CFG_WIDTH-1:0] BLINK_DELAY_RST = 16'd300;
    localparam logic [CFG_WIDTH-1:0] TAIL_DELAY_RST  = 16'd100;
    localparam logic [CFG_WIDTH-1:0] IDLE_DELAY_RST  = 16'd200;

    localparam logic [LED_WIDTH-1:0]  SCAN_LOW   = 10'h003;
    localparam logic [LED_WIDTH-1:0]  SCAN_HIGH  = 10'h300;
    localparam logic [LED_WIDTH-1:0]  COUNT_TOP  = 10'h3FF;
    localparam logic [FILL_WIDTH-1:0] FILL_FULL  = 5'h1F;
    localparam logic [FILL_WIDTH-1:0] FILL_MSB   = 5'h10;

    localparam logic [1:0] PHASE_BOTH  = 2'd0;
    localparam logic [1:0] PHASE_RIGHT = 2'd1;
    localparam logic [1:0] PHASE_LEFT  = 2'd2;

endpackage

`default_nettype wire

// File: src/led_pattern_sequencer.sv
// A result beat appears in m_tdata in the cycle after the tick beat that causes it.
// Throughput: one tick beat per cycle; a tick with a pending step yields one beat.
// A result beat held by m_tready low holds off every tick beat until it leaves.
// Reset (aresetn low, synchronous): delays return to defaults, no selection pending,
// idle mode, countdown zero so the first tick runs a step.
`default_nettype none

module led_pattern_sequencer
    import lps_pkg::*;
#(
    parameter int DELAY_WIDTH = DEF_DELAY_WIDTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_DATA_WIDTH-1:0]  s_tdata,   // [3:0] button_pins, [7:4] zero
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_DATA_WIDTH-1:0]       m_tdata,   // [9:0] led_bits, [13:10] mode_now, [15:14] zero
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]     cfg_data
);

    logic [CFG_WIDTH-1:0] scan_delay_reg, count_delay_reg, blink_delay_reg;
    logic [CFG_WIDTH-1:0] tail_delay_reg, idle_delay_reg;

    logic [MODE_WIDTH-1:0]  pending_choice_reg, pending_choice_next;
    logic                   pending_valid_reg, pending_valid_next;
    logic [MODE_WIDTH-1:0]  active_mode_reg, active_mode_next;
    logic                   restart_reg, restart_next;
    logic [1:0]             phase_reg, phase_next;
    logic [LED_WIDTH-1:0]   shown_reg, shown_next;
    logic [FILL_WIDTH-1:0]  left_fill_reg, left_fill_next;
    logic [FILL_WIDTH-1:0]  right_fill_reg, right_fill_next;
    logic [DELAY_WIDTH-1:0] countdown_reg, countdown_next;

    logic                    m_tvalid_reg;
    logic [LED_WIDTH-1:0]    led_out_reg;
    logic [MODE_WIDTH-1:0]   mode_out_reg;

    logic [MODE_WIDTH-1:0]  pressed;
    logic                   accept;
    logic                   emit;
    logic [LED_WIDTH-1:0]   led_out;
    logic [CFG_WIDTH-1:0]   delay_sel;
    logic [CFG_WIDTH-1:0]   delay_m1;
    logic [DELAY_WIDTH-1:0] reload;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, mode_out_reg, led_out_reg};
    assign pressed   = ~s_tdata[MODE_WIDTH-1:0];

    always_comb begin
        case (active_mode_next)
            MODE_SCAN:  delay_sel = scan_delay_reg;
            MODE_COUNT: delay_sel = count_delay_reg;
            MODE_BLINK: delay_sel = blink_delay_reg;
            MODE_TAIL:  delay_sel = tail_delay_reg;
            default:    delay_sel = idle_delay_reg;
        endcase
        delay_m1 = (delay_sel == '0) ? '0 : delay_sel - 1'b1;
    end

    generate
        if (DELAY_WIDTH >= CFG_WIDTH) begin : g_wide
            assign reload = DELAY_WIDTH'(delay_m1);
        end else begin : g_narrow
            assign reload = (|delay_m1[CFG_WIDTH-1:DELAY_WIDTH]) ? '1
                                                                 : delay_m1[DELAY_WIDTH-1:0];
        end
    endgenerate

    always_comb begin
        pending_choice_next = pending_choice_reg;
        pending_valid_next  = pending_valid_reg;
        active_mode_next    = active_mode_reg;
        restart_next        = restart_reg;
        phase_next          = phase_reg;
        shown_next          = shown_reg;
        left_fill_next      = left_fill_reg;
        right_fill_next     = right_fill_reg;
        countdown_next      = countdown_reg;
        emit                = 1'b0;
        led_out             = '0;

        if (accept) begin
            if (pressed != '0 && !pending_valid_reg) begin
                pending_choice_next = pressed;
                pending_valid_next  = 1'b1;
            end
            if (countdown_reg != '0) begin
                countdown_next = countdown_reg - 1'b1;
            end else begin
                emit = 1'b1;
                if (pending_valid_next) begin
                    if ((pending_choice_next & active_mode_reg) == '0) begin
                        active_mode_next = pending_choice_next;
                        restart_next     = 1'b1;
                    end
                    pending_valid_next = 1'b0;
                end
                case (active_mode_next)
                    MODE_SCAN: begin
                        if (restart_next) begin
                            shown_next   = SCAN_LOW;
                            restart_next = 1'b0;
                            phase_next   = PHASE_RIGHT;
                        end
                        led_out = shown_next;
                        if (phase_next != PHASE_BOTH) begin
                            shown_next = {shown_next[LED_WIDTH-2:0], 1'b0};
                            if (shown_next == SCAN_HIGH) begin
                                phase_next = PHASE_BOTH;
                            end
                        end else begin
                            shown_next = {1'b0, shown_next[LED_WIDTH-1:1]};
                            if (shown_next == SCAN_LOW) begin
                                phase_next = PHASE_RIGHT;
                            end
                        end
                    end
                    MODE_COUNT: begin
                        if (restart_next) begin
                            restart_next = 1'b0;
                            shown_next   = '0;
                        end
                        led_out    = shown_next;
                        shown_next = shown_next + 1'b1;
                        if (shown_next == COUNT_TOP) begin
                            shown_next = '0;
                        end
                    end
                    MODE_BLINK: begin
                        if (restart_next) begin
                            restart_next = 1'b0;
                            shown_next   = '0;
                        end
                        led_out    = shown_next;
                        shown_next = ~shown_next;
                    end
                    MODE_TAIL: begin
                        if (restart_next) begin
                            restart_next    = 1'b0;
                            shown_next      = '0;
                            phase_next      = PHASE_BOTH;
                            left_fill_next  = '0;
                            right_fill_next = '0;
                        end
                        if (phase_next == PHASE_BOTH || phase_next == PHASE_LEFT) begin
                            left_fill_next = left_fill_next
                                           | {left_fill_next[FILL_WIDTH-2:0], 1'b1};
                        end
                        if (phase_next == PHASE_BOTH || phase_next == PHASE_RIGHT) begin
                            right_fill_next = right_fill_next
                                            | {1'b0, right_fill_next[FILL_WIDTH-1:1]}
                                            | FILL_MSB;
                        end
                        case (phase_next)
                            PHASE_BOTH: shown_next = {
                                shown_next[LED_WIDTH-1:FILL_WIDTH] | left_fill_next,
                                shown_next[FILL_WIDTH-1:0] | right_fill_next};
                            PHASE_RIGHT: shown_next = {
                                shown_next[LED_WIDTH-1:FILL_WIDTH],
                                shown_next[FILL_WIDTH-1:0] | right_fill_next};
                            PHASE_LEFT: shown_next = {
                                shown_next[LED_WIDTH-1:FILL_WIDTH] | left_fill_next,
                                {FILL_WIDTH{1'b0}}};
                            default: shown_next = shown_next;
                        endcase
                        led_out = shown_next;
                        if (left_fill_next == FILL_FULL || right_fill_next == FILL_FULL) begin
                            shown_next      = '0;
                            left_fill_next  = '0;
                            right_fill_next = '0;
                            phase_next      = (phase_next == PHASE_BOTH) ? PHASE_RIGHT
                                            : (phase_next == PHASE_RIGHT) ? PHASE_LEFT
                                            : PHASE_BOTH;
                        end
                    end
                    default: begin
                        shown_next = '0;
                        led_out    = '0;
                    end
                endcase
                countdown_next = reload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_delay_reg     <= SCAN_DELAY_RST;
            count_delay_reg    <= COUNT_DELAY_RST;
            blink_delay_reg    <= BLINK_DELAY_RST;
            tail_delay_reg     <= TAIL_DELAY_RST;
            idle_delay_reg     <= IDLE_DELAY_RST;
            pending_choice_reg <= '0;
            pending_valid_reg  <= 1'b0;
            active_mode_reg    <= '0;
            restart_reg        <= 1'b1;
            phase_reg          <= PHASE_RIGHT;
            shown_reg          <= '0;
            left_fill_reg      <= '0;
            right_fill_reg     <= '0;
            countdown_reg      <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SCAN_DELAY:  scan_delay_reg  <= cfg_data;
                    REG_COUNT_DELAY: count_delay_reg <= cfg_data;
                    REG_BLINK_DELAY: blink_delay_reg <= cfg_data;
                    REG_TAIL_DELAY:  tail_delay_reg  <= cfg_data;
                    REG_IDLE_DELAY:  idle_delay_reg  <= cfg_data;
                    default: ;
                endcase
            end
            pending_choice_reg <= pending_choice_next;
            pending_valid_reg  <= pending_valid_next;
            active_mode_reg    <= active_mode_next;
            restart_reg        <= restart_next;
            phase_reg          <= phase_next;
            shown_reg          <= shown_next;
            left_fill_reg      <= left_fill_next;
            right_fill_reg     <= right_fill_next;
            countdown_reg      <= countdown_next;
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            led_out_reg  <= led_out;
            mode_out_reg <= active_mode_next;
        end
    end

endmodule

`default_nettype wire

// File: src/lps_checker.sv
`default_nettype none

`include "led_pattern_sequencer_macros.svh"

module lps_checker
    import lps_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    m_tvalid,
    input wire logic                    m_tready,
    input wire logic [M_DATA_WIDTH-1:0] m_tdata
);

    logic [LED_WIDTH-1:0]  led_bits;
    logic [MODE_WIDTH-1:0] mode_now;
    logic                  mode_known;

    assign led_bits   = m_tdata[LED_WIDTH-1:0];
    assign mode_now   = m_tdata[LED_WIDTH+MODE_WIDTH-1:LED_WIDTH];
    assign mode_known = (mode_now == MODE_SCAN) || (mode_now == MODE_COUNT)
                     || (mode_now == MODE_BLINK) || (mode_now == MODE_TAIL);

    `LPS_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")
    `LPS_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled beat changed")
    `LPS_ASSERT(a_scan_pair, aclk, aresetn, m_tvalid && mode_now == MODE_SCAN |-> $countones(led_bits) == 2, "scanner not a pair")
    `LPS_ASSERT(a_count_wrap, aclk, aresetn, m_tvalid && mode_now == MODE_COUNT |-> led_bits != COUNT_TOP, "counter reached top")
    `LPS_ASSERT(a_idle_dark, aclk, aresetn, m_tvalid && !mode_known |-> led_bits == '0, "idle mode lit")

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
